@@ rtl/core/signed_radix_digit_emitter_top_defines.svh @@
// Assertion macros for the radix digit emitter.
`ifndef SIGNED_RADIX_DIGIT_EMITTER_TOP_DEFINES_SVH
`define SIGNED_RADIX_DIGIT_EMITTER_TOP_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define SRDE_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication check failed");

// Next-cycle implication, disabled in reset.
`define SRDE_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

@@ rtl/core/srde_pkg.sv @@
// Shared types, constants and helpers for the radix digit emitter.
`default_nettype none
package srde_pkg;

   localparam int VALUE_W     = 32;
   localparam int ALPHA_SLOTS = 16;
   localparam int CHAR_W      = 8;
   localparam int DIGIT_W     = 4;
   localparam int MAX_DIGITS  = 32;
   localparam int ND_W        = 6;

   localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_DIV_GO,
      S_DIV_WAIT,
      S_SIGN,
      S_EMIT
   } state_type;

   typedef logic [DIGIT_W-1:0] digit_type;

   // Character k of the 16-slot alphabet {high word, low word}.
   function automatic logic [CHAR_W-1:0] alpha_char(
      input logic [ALPHA_SLOTS*CHAR_W-1:0] alpha,
      input logic [3:0]                    k
   );
      return alpha[{k, 3'b000} +: CHAR_W];
   endfunction

endpackage
`default_nettype wire

@@ rtl/core/signed_radix_digit_emitter_top.sv @@
// Top level: signed integer to radix string over a configured digit alphabet.
//
// Pulse start while busy is low to hand in req_value. The block first scans the alphabet one
// character per cycle; an invalid alphabet ends the word with no output. Each digit then
// takes 32 steps in the bit-serial divider, and the characters stream out one per cycle:
// '-' for a negative value, then the digits most significant first, rsp_last on the final
// one. rsp_valid strobes each character for one cycle; the receiver cannot stall, so it must
// take every character as it comes. Both alphabet registers reset to zero, which is an
// invalid alphabet.
`default_nettype none
`include "signed_radix_digit_emitter_top_defines.svh"
module signed_radix_digit_emitter_top #(
   parameter int MAX_RADIX = 16
) (
   input  wire logic                                       clock,
   input  wire logic                                       reset,
   input  wire logic                                       start,
   output logic                                            busy,
   input  wire logic signed [srde_pkg::VALUE_W-1:0]        req_value,
   output logic                                            rsp_valid,
   output logic             [srde_pkg::CHAR_W-1:0]         rsp_ch,
   output logic                                            rsp_last,
   input  wire logic                                       csr_we,
   input  wire logic                                       csr_index,
   input  wire logic        [63:0]                         csr_wdata
);

   localparam int LIMIT = (MAX_RADIX < srde_pkg::ALPHA_SLOTS) ? MAX_RADIX
                                                              : srde_pkg::ALPHA_SLOTS;
   localparam int RDW   = $clog2(LIMIT + 1);
   localparam int ND_W  = srde_pkg::ND_W;
   localparam int ND    = srde_pkg::MAX_DIGITS;

   srde_pkg::state_type             state_ff, state_in;
   logic [63:0]                     alpha_lo_ff, alpha_hi_ff;
   logic [RDW-1:0]                  idx_ff,   idx_in;
   logic [RDW-1:0]                  radix_ff, radix_in;
   logic                            neg_ff,   neg_in;
   logic [srde_pkg::VALUE_W-1:0]    mag_ff,   mag_in;
   logic [ND_W-1:0]                 nd_ff,    nd_in;
   srde_pkg::digit_type             stack_ff [ND];
   srde_pkg::digit_type             stack_in [ND];

   logic [srde_pkg::ALPHA_SLOTS*srde_pkg::CHAR_W-1:0] alpha;
   logic [srde_pkg::CHAR_W-1:0]     cur_char;
   logic                            at_end;
   logic                            bad_char;
   logic                            accept;
   logic                            div_go;
   logic                            div_done;
   logic [srde_pkg::VALUE_W-1:0]    div_quo;
   srde_pkg::digit_type             div_rem;

   assign alpha    = {alpha_hi_ff, alpha_lo_ff};
   assign accept   = start && (state_ff == srde_pkg::S_IDLE);
   assign cur_char = srde_pkg::alpha_char(alpha, 4'(idx_ff));
   assign at_end   = (idx_ff == RDW'(LIMIT)) || (cur_char == '0);

   // sign chars, or a repeat of any earlier character
   always_comb begin
      bad_char = (cur_char == srde_pkg::CH_MINUS) || (cur_char == srde_pkg::CH_PLUS);
      for (int j = 0; j < LIMIT; j++) begin
         if ((idx_ff > RDW'(j)) && (srde_pkg::alpha_char(alpha, 4'(j)) == cur_char)) begin
            bad_char = 1'b1;
         end
      end
   end

   srde_div #(
      .RDW (RDW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .go        (div_go),
      .dividend  (mag_ff),
      .divisor   (radix_ff),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         srde_pkg::S_IDLE: begin
            if (start) state_in = srde_pkg::S_CHECK;
         end
         srde_pkg::S_CHECK: begin
            if (at_end) begin
               state_in = (idx_ff <= RDW'(1)) ? srde_pkg::S_IDLE : srde_pkg::S_DIV_GO;
            end else if (bad_char) begin
               state_in = srde_pkg::S_IDLE;
            end
         end
         srde_pkg::S_DIV_GO: begin
            state_in = srde_pkg::S_DIV_WAIT;
         end
         srde_pkg::S_DIV_WAIT: begin
            if (div_done) begin
               if ((div_quo == '0) || (nd_ff == ND_W'(ND - 1))) begin
                  state_in = neg_ff ? srde_pkg::S_SIGN : srde_pkg::S_EMIT;
               end else begin
                  state_in = srde_pkg::S_DIV_GO;
               end
            end
         end
         srde_pkg::S_SIGN: begin
            state_in = srde_pkg::S_EMIT;
         end
         srde_pkg::S_EMIT: begin
            if (nd_ff == ND_W'(1)) state_in = srde_pkg::S_IDLE;
         end
         default: begin
            state_in = srde_pkg::S_IDLE;
         end
      endcase
   end

   // datapath
   always_comb begin
      idx_in   = idx_ff;
      radix_in = radix_ff;
      neg_in   = neg_ff;
      mag_in   = mag_ff;
      nd_in    = nd_ff;
      for (int k = 0; k < ND; k++) stack_in[k] = stack_ff[k];
      case (state_ff)
         srde_pkg::S_IDLE: begin
            if (accept) begin
               neg_in = req_value[srde_pkg::VALUE_W-1];
               mag_in = req_value[srde_pkg::VALUE_W-1] ? srde_pkg::VALUE_W'(-req_value)
                                                       : srde_pkg::VALUE_W'(req_value);
               idx_in = '0;
               nd_in  = '0;
            end
         end
         srde_pkg::S_CHECK: begin
            if (at_end) radix_in = idx_ff;
            else        idx_in   = RDW'(idx_ff + 1'b1);
         end
         srde_pkg::S_DIV_WAIT: begin
            if (div_done) begin
               stack_in[0] = div_rem;
               for (int k = 1; k < ND; k++) stack_in[k] = stack_ff[k-1];
               nd_in  = ND_W'(nd_ff + 1'b1);
               mag_in = div_quo;
            end
         end
         srde_pkg::S_EMIT: begin
            for (int k = 0; k < ND - 1; k++) stack_in[k] = stack_ff[k+1];
            stack_in[ND-1] = '0;
            nd_in = ND_W'(nd_ff - 1'b1);
         end
         default: begin
         end
      endcase
   end

   // outputs
   always_comb begin
      busy      = (state_ff != srde_pkg::S_IDLE);
      div_go    = (state_ff == srde_pkg::S_DIV_GO);
      rsp_valid = 1'b0;
      rsp_last  = 1'b0;
      rsp_ch    = srde_pkg::alpha_char(alpha, stack_ff[0]);
      case (state_ff)
         srde_pkg::S_SIGN: begin
            rsp_valid = 1'b1;
            rsp_ch    = srde_pkg::CH_MINUS;
         end
         srde_pkg::S_EMIT: begin
            rsp_valid = 1'b1;
            rsp_last  = (nd_ff == ND_W'(1));
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= srde_pkg::S_IDLE;
         alpha_lo_ff <= '0;
         alpha_hi_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_we && !csr_index) alpha_lo_ff <= csr_wdata;
         if (csr_we &&  csr_index) alpha_hi_ff <= csr_wdata;
      end
      idx_ff   <= idx_in;
      radix_ff <= radix_in;
      neg_ff   <= neg_in;
      mag_ff   <= mag_in;
      nd_ff    <= nd_in;
      for (int k = 0; k < ND; k++) stack_ff[k] <= stack_in[k];
   end

   `SRDE_ASSERT_IMP(a_strobe_busy, clock, reset, rsp_valid, busy)
   `SRDE_ASSERT_NXT(a_last_ends, clock, reset, rsp_valid && rsp_last, !rsp_valid && !busy)
   `SRDE_ASSERT_NXT(a_accept_busy, clock, reset, start && !busy, busy)
   `SRDE_ASSERT_IMP(a_digit_cap, clock, reset, busy, nd_ff <= ND_W'(ND))
   `SRDE_ASSERT_IMP(a_emit_nonempty, clock, reset,
      state_ff == srde_pkg::S_EMIT, nd_ff != '0)

endmodule
`default_nettype wire

@@ rtl/core/srde_div.sv @@
// Bit-serial restoring divider: 32-bit word by a narrow radix, one bit per cycle.
`default_nettype none
module srde_div #(
   parameter int RDW = 5
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               go,
   input  wire logic [srde_pkg::VALUE_W-1:0]       dividend,
   input  wire logic [RDW-1:0]                     divisor,
   output logic                                    done,
   output logic      [srde_pkg::VALUE_W-1:0]       quotient,
   output logic      [srde_pkg::DIGIT_W-1:0]       remainder
);

   localparam int CNT_W = $clog2(srde_pkg::VALUE_W);

   logic                           run_ff,  run_in;
   logic                           done_ff, done_in;
   logic [CNT_W-1:0]               cnt_ff,  cnt_in;
   logic [RDW-1:0]                 rem_ff,  rem_in;
   logic [srde_pkg::VALUE_W-1:0]   quo_ff,  quo_in;

   logic [RDW:0] trial;
   logic         fits;

   always_comb begin
      trial   = {rem_ff, quo_ff[srde_pkg::VALUE_W-1]};
      fits    = trial >= {1'b0, divisor};
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (go) begin
         run_in = 1'b1;
         cnt_in = '0;
         rem_in = '0;
         quo_in = dividend;
      end else if (run_ff) begin
         rem_in = fits ? RDW'(trial - {1'b0, divisor}) : RDW'(trial);
         quo_in = {quo_ff[srde_pkg::VALUE_W-2:0], fits};
         cnt_in = CNT_W'(cnt_ff + 1'b1);
         if (cnt_ff == CNT_W'(srde_pkg::VALUE_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = srde_pkg::DIGIT_W'(rem_ff);

endmodule
`default_nettype wire
